/* rtl/core/mms_pkg.sv */
// Package for the mission-mode sequencer: mode, attitude, role and function
// codes, register indexes, field widths and shared types.
// No dependencies.
`default_nettype none

package mms_pkg;

   // field widths
   localparam int unsigned ModeW       = 4;
   localparam int unsigned AttW        = 4;
   localparam int unsigned RoleW       = 2;
   localparam int unsigned FuncW       = 2;
   localparam int unsigned CmdW        = 4;
   localparam int unsigned RateW       = 16;
   localparam int unsigned BaseW       = 24;
   localparam int unsigned TickW       = 32;
   localparam int unsigned DeployW     = 14;
   localparam int unsigned RateSqW     = 32;
   localparam int unsigned DistSqW     = 48;
   localparam int unsigned CsrDataW    = 64;
   localparam int unsigned CsrAddrW    = 6;
   localparam int unsigned ReqDataW    = 160;
   localparam int unsigned RspDataW    = 32;

   typedef logic [ModeW-1:0] mode_type;
   typedef logic [AttW-1:0]  att_type;
   typedef logic [RoleW-1:0] role_type;
   typedef logic [FuncW-1:0] func_type;
   typedef logic [2:0]       reg_index_type;

   // mission modes
   localparam mode_type M_STARTUP  = 4'd0;
   localparam mode_type M_DETUMBLE = 4'd1;
   localparam mode_type M_INITHOLD = 4'd2;
   localparam mode_type M_FOLLOWER = 4'd3;
   localparam mode_type M_FCLOSE   = 4'd4;
   localparam mode_type M_STANDBY  = 4'd5;
   localparam mode_type M_LEADER   = 4'd6;
   localparam mode_type M_LCLOSE   = 4'd7;
   localparam mode_type M_DOCKING  = 4'd8;
   localparam mode_type M_DOCKED   = 4'd9;
   localparam mode_type M_PAIRED   = 4'd10;
   localparam mode_type M_JUNK     = 4'd11;
   localparam mode_type M_SAFEHOLD = 4'd12;
   localparam mode_type M_MANUAL   = 4'd13;

   // attitude modes
   localparam att_type A_STARTUP     = 4'd0;
   localparam att_type A_DETUMBLE    = 4'd1;
   localparam att_type A_PT_STANDBY  = 4'd2;
   localparam att_type A_PT_DOCKING  = 4'd3;
   localparam att_type A_ZERO_TORQUE = 4'd4;
   localparam att_type A_ZERO_L      = 4'd5;
   localparam att_type A_LIMITED     = 4'd6;
   localparam att_type A_SINGLE      = 4'd7;
   localparam att_type A_PAIRED      = 4'd8;

   // designation
   localparam role_type R_UNDECIDED = 2'd0;
   localparam role_type R_FOLLOWER  = 2'd1;
   localparam role_type R_LEADER    = 2'd2;

   // item function
   localparam func_type F_TICK     = 2'd0;
   localparam func_type F_SET_MODE = 2'd1;
   localparam func_type F_SET_ROLE = 2'd2;

   // register indexes
   localparam reg_index_type REG_DEPLOY_WAIT  = 3'd0;
   localparam reg_index_type REG_RATE_LIMIT   = 3'd1;
   localparam reg_index_type REG_APPROACH     = 3'd2;
   localparam reg_index_type REG_DOCK         = 3'd3;
   localparam reg_index_type REG_MAX_SILENCE  = 3'd4;

   // sensor decisions handed to the mode update stage
   typedef struct packed {
      logic rate_ok;
      logic near_app;
      logic near_dock;
      logic is_docked;
   } tick_flags_type;

endpackage

`default_nettype wire

/* rtl/core/mission_mode_sequencer_core.sv */
// Mission-mode sequencer top level: stream in/out, APB-style register port.
// Depends on mms_pkg.
`default_nettype none

// Takes one item per clock and returns exactly one result item per input
// item, the mission state after that item. An accepted item passes the input
// register, then a stage that squares the body rate and baseline components,
// one that sums and compares them against the configured limits, and the
// last, which applies the mode transition and holds the result.
// Sustained rate is one item per cycle while rsp_tready stays high; a stall
// on the result side backs up through the stages to req_tready. Registers
// sit at byte address 8*i and must be written while no item is in flight.
module mission_mode_sequencer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tuser: func[1:0]
   // req_tdata: cmd_value[3:0], rate_x[19:4], rate_y[35:20], rate_z[51:36],
   //   base_x[75:52], base_y[99:76], base_z[123:100], base_valid[124],
   //   last_comms_tick[156:125], is_docked[157], zero[159:158]
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [mms_pkg::ReqDataW-1:0]   req_tdata,
   input  wire logic [mms_pkg::FuncW-1:0]      req_tuser,
   // rsp_tdata: mission_mode[3:0], attitude_mode[7:4], prop_active[8],
   //   radio_active[9], sat_role[11:10], dock_command[12],
   //   deploy_elapsed[26:13], zero[31:27]
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [mms_pkg::RspDataW-1:0]        rsp_tdata,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [mms_pkg::CsrAddrW-1:0]   csr_paddr,
   input  wire logic [mms_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [mms_pkg::CsrDataW-1:0]        csr_prdata,
   output logic                                csr_pready
);

   // ---------------- configuration ----------------
   logic [mms_pkg::DeployW-1:0] deploy_wait_ff;
   logic [mms_pkg::RateSqW-1:0] rate_limit_ff;
   logic [mms_pkg::DistSqW-1:0] approach_ff;
   logic [mms_pkg::DistSqW-1:0] dock_dist_ff;
   logic [mms_pkg::TickW-1:0]   max_silence_ff;

   mms_pkg::reg_index_type csr_index;
   logic                   csr_wr;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         deploy_wait_ff <= '0;
         rate_limit_ff  <= '0;
         approach_ff    <= '0;
         dock_dist_ff   <= '0;
         max_silence_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            mms_pkg::REG_DEPLOY_WAIT: deploy_wait_ff <= csr_pwdata[13:0];
            mms_pkg::REG_RATE_LIMIT:  rate_limit_ff  <= csr_pwdata[31:0];
            mms_pkg::REG_APPROACH:    approach_ff    <= csr_pwdata[47:0];
            mms_pkg::REG_DOCK:        dock_dist_ff   <= csr_pwdata[47:0];
            mms_pkg::REG_MAX_SILENCE: max_silence_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mms_pkg::REG_DEPLOY_WAIT: csr_prdata = 64'(deploy_wait_ff);
         mms_pkg::REG_RATE_LIMIT:  csr_prdata = 64'(rate_limit_ff);
         mms_pkg::REG_APPROACH:    csr_prdata = 64'(approach_ff);
         mms_pkg::REG_DOCK:        csr_prdata = 64'(dock_dist_ff);
         mms_pkg::REG_MAX_SILENCE: csr_prdata = 64'(max_silence_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, s3_ready, s2_ready, s1_ready;
   logic out_fire;

   assign out_ready  = ~rsp_valid_ff | rsp_tready;
   assign s3_ready   = ~s3_valid_ff | out_ready;
   assign s2_ready   = ~s2_valid_ff | s3_ready;
   assign s1_ready   = ~s1_valid_ff | s2_ready;
   assign req_tready = s1_ready;
   assign out_fire   = s3_valid_ff & out_ready;

   assign s1_valid_in  = s1_ready ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = out_ready ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   mms_pkg::func_type               s1_func_ff;
   logic [mms_pkg::CmdW-1:0]        s1_cmd_ff;
   logic signed [mms_pkg::RateW-1:0] s1_rate_x_ff, s1_rate_y_ff, s1_rate_z_ff;
   logic signed [mms_pkg::BaseW-1:0] s1_base_x_ff, s1_base_y_ff, s1_base_z_ff;
   logic                            s1_base_valid_ff;
   logic [mms_pkg::TickW-1:0]       s1_last_comms_ff;
   logic                            s1_docked_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_func_ff       <= req_tuser;
         s1_cmd_ff        <= req_tdata[3:0];
         s1_rate_x_ff     <= req_tdata[19:4];
         s1_rate_y_ff     <= req_tdata[35:20];
         s1_rate_z_ff     <= req_tdata[51:36];
         s1_base_x_ff     <= req_tdata[75:52];
         s1_base_y_ff     <= req_tdata[99:76];
         s1_base_z_ff     <= req_tdata[123:100];
         s1_base_valid_ff <= req_tdata[124];
         s1_last_comms_ff <= req_tdata[156:125];
         s1_docked_ff     <= req_tdata[157];
      end
   end

   // ---------------- stage 2: squares ----------------
   // signed squares are never negative; top bit of the product is dropped
   logic signed [2*mms_pkg::RateW-1:0] rx_sq, ry_sq, rz_sq;
   logic signed [2*mms_pkg::BaseW-1:0] bx_sq, by_sq, bz_sq;

   assign rx_sq = s1_rate_x_ff * s1_rate_x_ff;
   assign ry_sq = s1_rate_y_ff * s1_rate_y_ff;
   assign rz_sq = s1_rate_z_ff * s1_rate_z_ff;
   assign bx_sq = s1_base_x_ff * s1_base_x_ff;
   assign by_sq = s1_base_y_ff * s1_base_y_ff;
   assign bz_sq = s1_base_z_ff * s1_base_z_ff;

   mms_pkg::func_type          s2_func_ff;
   logic [mms_pkg::CmdW-1:0]   s2_cmd_ff;
   logic [30:0]                s2_rx_sq_ff, s2_ry_sq_ff, s2_rz_sq_ff;
   logic [46:0]                s2_bx_sq_ff, s2_by_sq_ff, s2_bz_sq_ff;
   logic                       s2_base_valid_ff;
   logic [mms_pkg::TickW-1:0]  s2_last_comms_ff;
   logic                       s2_docked_ff;

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_func_ff       <= s1_func_ff;
         s2_cmd_ff        <= s1_cmd_ff;
         s2_rx_sq_ff      <= rx_sq[30:0];
         s2_ry_sq_ff      <= ry_sq[30:0];
         s2_rz_sq_ff      <= rz_sq[30:0];
         s2_bx_sq_ff      <= bx_sq[46:0];
         s2_by_sq_ff      <= by_sq[46:0];
         s2_bz_sq_ff      <= bz_sq[46:0];
         s2_base_valid_ff <= s1_base_valid_ff;
         s2_last_comms_ff <= s1_last_comms_ff;
         s2_docked_ff     <= s1_docked_ff;
      end
   end

   // ---------------- stage 3: sums and limit compares ----------------
   logic [mms_pkg::RateSqW-1:0] rate_sum;
   logic [mms_pkg::DistSqW-1:0] dist_sum;
   mms_pkg::tick_flags_type     flags;

   // three squares of 2^30 / 2^46 at most: the sums fit without carry out
   assign rate_sum = 32'(s2_rx_sq_ff) + 32'(s2_ry_sq_ff) + 32'(s2_rz_sq_ff);
   assign dist_sum = 48'(s2_bx_sq_ff) + 48'(s2_by_sq_ff) + 48'(s2_bz_sq_ff);

   assign flags.rate_ok   = rate_sum <= rate_limit_ff;
   assign flags.near_app  = s2_base_valid_ff & (dist_sum < approach_ff);
   assign flags.near_dock = s2_base_valid_ff & (dist_sum < dock_dist_ff);
   assign flags.is_docked = s2_docked_ff;

   mms_pkg::func_type          s3_func_ff;
   logic [mms_pkg::CmdW-1:0]   s3_cmd_ff;
   mms_pkg::tick_flags_type    s3_flags_ff;
   logic [mms_pkg::TickW-1:0]  s3_last_comms_ff;

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_func_ff       <= s2_func_ff;
         s3_cmd_ff        <= s2_cmd_ff;
         s3_flags_ff      <= flags;
         s3_last_comms_ff <= s2_last_comms_ff;
      end
   end

   // ---------------- stage 4: mode update, holds the result ----------------
   mms_pkg::mode_type           mode_ff, mode_in;
   mms_pkg::att_type            att_ff, att_in;
   logic                        prop_ff, prop_in;
   logic                        radio_ff, radio_in;
   mms_pkg::role_type           role_ff, role_in;
   logic                        dock_cmd_ff, dock_cmd_in;
   logic [mms_pkg::DeployW-1:0] deploy_ff, deploy_in;
   logic [mms_pkg::TickW-1:0]   tick_ff, tick_in;

   logic [mms_pkg::TickW-1:0]   silence;
   logic                        silent;
   logic                        is_fol;

   assign silence = tick_ff - s3_last_comms_ff;
   assign silent  = silence > max_silence_ff;
   // follower-side modes pick the follower role and close approach
   assign is_fol  = (mode_ff == mms_pkg::M_FOLLOWER) || (mode_ff == mms_pkg::M_FCLOSE);

   always_comb begin
      mode_in     = mode_ff;
      att_in      = att_ff;
      prop_in     = prop_ff;
      radio_in    = radio_ff;
      role_in     = role_ff;
      dock_cmd_in = dock_cmd_ff;
      deploy_in   = deploy_ff;
      tick_in     = tick_ff;
      if (out_fire) begin
         unique case (s3_func_ff)
            mms_pkg::F_TICK: begin
               tick_in = tick_ff + 32'd1;
               unique case (mode_ff)
                  mms_pkg::M_STARTUP: begin
                     att_in   = mms_pkg::A_STARTUP;
                     prop_in  = 1'b0;
                     radio_in = 1'b0;
                     if (deploy_ff < deploy_wait_ff) begin
                        deploy_in = deploy_ff + 14'd1;
                     end else begin
                        mode_in = mms_pkg::M_DETUMBLE;
                     end
                  end
                  mms_pkg::M_DETUMBLE: begin
                     att_in   = mms_pkg::A_DETUMBLE;
                     prop_in  = 1'b0;
                     radio_in = 1'b1;
                     if (s3_flags_ff.rate_ok) begin
                        att_in  = mms_pkg::A_PT_STANDBY;
                        mode_in = mms_pkg::M_STANDBY;
                     end
                  end
                  mms_pkg::M_INITHOLD: begin
                     att_in   = mms_pkg::A_DETUMBLE;
                     prop_in  = 1'b0;
                     radio_in = 1'b1;
                  end
                  mms_pkg::M_FOLLOWER, mms_pkg::M_LEADER: begin
                     role_in  = is_fol ? mms_pkg::R_FOLLOWER : mms_pkg::R_LEADER;
                     att_in   = mms_pkg::A_PT_STANDBY;
                     prop_in  = is_fol;
                     radio_in = 1'b1;
                     if (silent) begin
                        role_in = mms_pkg::R_UNDECIDED;
                        mode_in = mms_pkg::M_STANDBY;
                     end
                     // distance test wins over comms loss
                     if (s3_flags_ff.near_app) begin
                        mode_in = is_fol ? mms_pkg::M_FCLOSE : mms_pkg::M_LCLOSE;
                     end
                  end
                  mms_pkg::M_FCLOSE, mms_pkg::M_LCLOSE: begin
                     role_in  = is_fol ? mms_pkg::R_FOLLOWER : mms_pkg::R_LEADER;
                     att_in   = mms_pkg::A_PT_DOCKING;
                     prop_in  = 1'b1;
                     radio_in = 1'b1;
                     if (silent) begin
                        role_in = mms_pkg::R_UNDECIDED;
                        att_in  = mms_pkg::A_PT_STANDBY;
                        mode_in = mms_pkg::M_STANDBY;
                     end
                     if (s3_flags_ff.near_dock) begin
                        mode_in = mms_pkg::M_DOCKING;
                     end
                  end
                  mms_pkg::M_STANDBY: begin
                     prop_in  = 1'b1;
                     radio_in = 1'b1;
                     if (role_ff == mms_pkg::R_FOLLOWER) begin
                        att_in  = mms_pkg::A_SINGLE;
                        mode_in = mms_pkg::M_FOLLOWER;
                     end else if (role_ff == mms_pkg::R_LEADER) begin
                        att_in  = mms_pkg::A_SINGLE;
                        mode_in = mms_pkg::M_LEADER;
                     end
                  end
                  mms_pkg::M_DOCKING: begin
                     att_in      = mms_pkg::A_ZERO_TORQUE;
                     prop_in     = 1'b0;
                     radio_in    = 1'b1;
                     dock_cmd_in = 1'b1;
                     if (s3_flags_ff.is_docked) begin
                        mode_in = mms_pkg::M_DOCKED;
                     end
                  end
                  mms_pkg::M_DOCKED: begin
                     att_in   = mms_pkg::A_ZERO_TORQUE;
                     prop_in  = 1'b0;
                     radio_in = 1'b1;
                     role_in  = mms_pkg::R_UNDECIDED;
                  end
                  mms_pkg::M_PAIRED: begin
                     role_in = mms_pkg::R_UNDECIDED;
                     att_in  = mms_pkg::A_PAIRED;
                     mode_in = mms_pkg::M_STANDBY;
                  end
                  mms_pkg::M_JUNK: begin
                     att_in   = mms_pkg::A_ZERO_L;
                     prop_in  = 1'b0;
                     radio_in = 1'b1;
                     role_in  = mms_pkg::R_UNDECIDED;
                  end
                  mms_pkg::M_SAFEHOLD: begin
                     att_in   = mms_pkg::A_LIMITED;
                     prop_in  = 1'b0;
                     radio_in = 1'b1;
                  end
                  mms_pkg::M_MANUAL: ;
                  default: mode_in = mms_pkg::M_SAFEHOLD;
               endcase
            end
            mms_pkg::F_SET_MODE: mode_in = s3_cmd_ff;
            mms_pkg::F_SET_ROLE: begin
               if (s3_cmd_ff <= 4'(mms_pkg::R_LEADER)) begin
                  role_in = s3_cmd_ff[1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= mms_pkg::M_STARTUP;
         att_ff      <= mms_pkg::A_STARTUP;
         prop_ff     <= 1'b0;
         radio_ff    <= 1'b0;
         role_ff     <= mms_pkg::R_UNDECIDED;
         dock_cmd_ff <= 1'b0;
         deploy_ff   <= '0;
         tick_ff     <= '0;
      end else begin
         mode_ff     <= mode_in;
         att_ff      <= att_in;
         prop_ff     <= prop_in;
         radio_ff    <= radio_in;
         role_ff     <= role_in;
         dock_cmd_ff <= dock_cmd_in;
         deploy_ff   <= deploy_in;
         tick_ff     <= tick_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, deploy_ff, dock_cmd_ff, role_ff, radio_ff, prop_ff,
                        att_ff, mode_ff};

endmodule

`default_nettype wire

/* tb/tb_mission_mode_sequencer_core.sv */
// Self-checking testbench for mission_mode_sequencer_core: streams control ticks
// and ground writes, predicts every result item and compares it field by field.
// Depends on mms_pkg and the core; stands alone otherwise.
`timescale 1ns / 100ps

module tb_mission_mode_sequencer_core;

   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned PRESSURE_AT     = 300;
   localparam int unsigned PRESSURE_CYCLES = 80;

   // codes the package leaves unnamed
   localparam mms_pkg::func_type         F_UNUSED     = 2'd3;
   localparam mms_pkg::mode_type         M_INVALID    = 4'd14;
   localparam logic [mms_pkg::CmdW-1:0]  CMD_BAD_ROLE = 4'd3;

   typedef struct {
      mms_pkg::func_type                func;
      logic [mms_pkg::CmdW-1:0]         cmd;
      logic signed [mms_pkg::RateW-1:0] rate_x, rate_y, rate_z;
      logic signed [mms_pkg::BaseW-1:0] base_x, base_y, base_z;
      logic                             base_valid;
      logic [mms_pkg::TickW-1:0]        last_comms;
      logic                             is_docked;
   } sensor_item_type;

   // same bit order as rsp_tdata[26:0]
   typedef struct packed {
      logic [mms_pkg::DeployW-1:0] deploy;
      logic                        dock;
      mms_pkg::role_type           role;
      logic                        radio;
      logic                        prop;
      mms_pkg::att_type            att;
      mms_pkg::mode_type           mode;
   } mission_status_type;

   class sequencer_scoreboard_type;
      logic [mms_pkg::DeployW-1:0] deploy_limit;
      logic [mms_pkg::RateSqW-1:0] rate_limit;
      logic [mms_pkg::DistSqW-1:0] approach_limit;
      logic [mms_pkg::DistSqW-1:0] dock_limit;
      logic [mms_pkg::TickW-1:0]   silence_limit;

      mms_pkg::mode_type           mode;
      mms_pkg::att_type            att;
      logic                        prop, radio, dock_cmd;
      mms_pkg::role_type           role;
      logic [mms_pkg::DeployW-1:0] deploy_cnt;
      logic [mms_pkg::TickW-1:0]   tick_count;

      mission_status_type          expected_status[$];
      int unsigned                 errors;

      function new();
         deploy_limit = '0;
         rate_limit = '0;
         approach_limit = '0;
         dock_limit = '0;
         silence_limit = '0;
         mode = mms_pkg::M_STARTUP;
         att = mms_pkg::A_STARTUP;
         prop = 1'b0;
         radio = 1'b0;
         dock_cmd = 1'b0;
         role = mms_pkg::R_UNDECIDED;
         deploy_cnt = '0;
         tick_count = '0;
         errors = 0;
      endfunction

      function void set_register(mms_pkg::reg_index_type idx,
                                 logic [mms_pkg::CsrDataW-1:0] value);
         case (idx)
            mms_pkg::REG_DEPLOY_WAIT: deploy_limit = value[mms_pkg::DeployW-1:0];
            mms_pkg::REG_RATE_LIMIT:  rate_limit = value[mms_pkg::RateSqW-1:0];
            mms_pkg::REG_APPROACH:    approach_limit = value[mms_pkg::DistSqW-1:0];
            mms_pkg::REG_DOCK:        dock_limit = value[mms_pkg::DistSqW-1:0];
            mms_pkg::REG_MAX_SILENCE: silence_limit = value[mms_pkg::TickW-1:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] square_of(longint v);
         return v * v;
      endfunction

      function void apply_outputs(mms_pkg::att_type a, logic p, logic r);
         att = a;
         prop = p;
         radio = r;
      endfunction

      function void advance_mission(sensor_item_type it);
         logic [63:0]               rate_sum, dist_sum;
         logic [mms_pkg::TickW-1:0] quiet_for;
         logic                      silent, near_app, near_dock, follow;
         mms_pkg::mode_type         next_mode;
         rate_sum = square_of(it.rate_x) + square_of(it.rate_y) + square_of(it.rate_z);
         dist_sum = square_of(it.base_x) + square_of(it.base_y) + square_of(it.base_z);
         quiet_for = tick_count - it.last_comms;
         silent = quiet_for > silence_limit;
         near_app = it.base_valid && (dist_sum < {16'b0, approach_limit});
         near_dock = it.base_valid && (dist_sum < {16'b0, dock_limit});
         case (mode)
            mms_pkg::M_STARTUP: begin
               apply_outputs(mms_pkg::A_STARTUP, 1'b0, 1'b0);
               if (deploy_cnt < deploy_limit) deploy_cnt = deploy_cnt + 1'b1;
               else mode = mms_pkg::M_DETUMBLE;
            end
            mms_pkg::M_DETUMBLE: begin
               apply_outputs(mms_pkg::A_DETUMBLE, 1'b0, 1'b1);
               if (rate_sum <= {32'b0, rate_limit}) begin
                  att = mms_pkg::A_PT_STANDBY;
                  mode = mms_pkg::M_STANDBY;
               end
            end
            mms_pkg::M_INITHOLD: apply_outputs(mms_pkg::A_DETUMBLE, 1'b0, 1'b1);
            mms_pkg::M_FOLLOWER, mms_pkg::M_LEADER: begin
               follow = (mode == mms_pkg::M_FOLLOWER);
               next_mode = follow ? mms_pkg::M_FCLOSE : mms_pkg::M_LCLOSE;
               role = follow ? mms_pkg::R_FOLLOWER : mms_pkg::R_LEADER;
               apply_outputs(mms_pkg::A_PT_STANDBY, follow, 1'b1);
               if (silent) begin
                  role = mms_pkg::R_UNDECIDED;
                  mode = mms_pkg::M_STANDBY;
               end
               // distance test wins over comms loss
               if (near_app) mode = next_mode;
            end
            mms_pkg::M_FCLOSE, mms_pkg::M_LCLOSE: begin
               role = (mode == mms_pkg::M_FCLOSE) ? mms_pkg::R_FOLLOWER : mms_pkg::R_LEADER;
               apply_outputs(mms_pkg::A_PT_DOCKING, 1'b1, 1'b1);
               if (silent) begin
                  role = mms_pkg::R_UNDECIDED;
                  att = mms_pkg::A_PT_STANDBY;
                  mode = mms_pkg::M_STANDBY;
               end
               if (near_dock) mode = mms_pkg::M_DOCKING;
            end
            mms_pkg::M_STANDBY: begin
               prop = 1'b1;
               radio = 1'b1;
               if (role == mms_pkg::R_FOLLOWER) begin
                  att = mms_pkg::A_SINGLE;
                  mode = mms_pkg::M_FOLLOWER;
               end else if (role == mms_pkg::R_LEADER) begin
                  att = mms_pkg::A_SINGLE;
                  mode = mms_pkg::M_LEADER;
               end
            end
            mms_pkg::M_DOCKING: begin
               apply_outputs(mms_pkg::A_ZERO_TORQUE, 1'b0, 1'b1);
               dock_cmd = 1'b1;
               if (it.is_docked) mode = mms_pkg::M_DOCKED;
            end
            mms_pkg::M_DOCKED: begin
               apply_outputs(mms_pkg::A_ZERO_TORQUE, 1'b0, 1'b1);
               role = mms_pkg::R_UNDECIDED;
            end
            mms_pkg::M_PAIRED: begin
               role = mms_pkg::R_UNDECIDED;
               att = mms_pkg::A_PAIRED;
               mode = mms_pkg::M_STANDBY;
            end
            mms_pkg::M_JUNK: begin
               apply_outputs(mms_pkg::A_ZERO_L, 1'b0, 1'b1);
               role = mms_pkg::R_UNDECIDED;
            end
            mms_pkg::M_SAFEHOLD: apply_outputs(mms_pkg::A_LIMITED, 1'b0, 1'b1);
            mms_pkg::M_MANUAL: ;
            default: mode = mms_pkg::M_SAFEHOLD;
         endcase
         tick_count = tick_count + 1'b1;
      endfunction

      function void note_item(sensor_item_type it);
         mission_status_type s;
         if (it.func == mms_pkg::F_TICK) begin
            advance_mission(it);
         end else if (it.func == mms_pkg::F_SET_MODE) begin
            mode = it.cmd;
         end else if (it.func == mms_pkg::F_SET_ROLE &&
                      it.cmd <= mms_pkg::CmdW'(mms_pkg::R_LEADER)) begin
            role = it.cmd[mms_pkg::RoleW-1:0];
         end
         s.mode = mode;
         s.att = att;
         s.prop = prop;
         s.radio = radio;
         s.role = role;
         s.dock = dock_cmd;
         s.deploy = deploy_cnt;
         expected_status.push_back(s);
      endfunction

      function void check_result(logic [mms_pkg::RspDataW-1:0] data);
         mission_status_type got, want;
         got = mission_status_type'(data[$bits(mission_status_type)-1:0]);
         if (expected_status.size() == 0) begin
            $error("result item %h arrived with nothing expected", data);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.mode !== want.mode) begin
            $error("mission_mode: expected %0d, got %0d", want.mode, got.mode);
            errors++;
         end
         if (got.att !== want.att) begin
            $error("attitude_mode: expected %0d, got %0d", want.att, got.att);
            errors++;
         end
         if (got.prop !== want.prop) begin
            $error("prop_active: expected %0d, got %0d", want.prop, got.prop);
            errors++;
         end
         if (got.radio !== want.radio) begin
            $error("radio_active: expected %0d, got %0d", want.radio, got.radio);
            errors++;
         end
         if (got.role !== want.role) begin
            $error("sat_role: expected %0d, got %0d", want.role, got.role);
            errors++;
         end
         if (got.dock !== want.dock) begin
            $error("dock_command: expected %0d, got %0d", want.dock, got.dock);
            errors++;
         end
         if (got.deploy !== want.deploy) begin
            $error("deploy_elapsed: expected %0d, got %0d", want.deploy, got.deploy);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_status.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mms_pkg::ReqDataW-1:0]   req_tdata = '0;
   logic [mms_pkg::FuncW-1:0]      req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [mms_pkg::RspDataW-1:0]   rsp_tdata;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [mms_pkg::CsrAddrW-1:0]   csr_paddr = '0;
   logic [mms_pkg::CsrDataW-1:0]   csr_pwdata = '0;
   logic [mms_pkg::CsrDataW-1:0]   csr_prdata;
   logic                           csr_pready;

   sequencer_scoreboard_type board;
   int unsigned              send_pct = 0;
   int unsigned              take_pct = 0;
   int unsigned              results_seen = 0;
   int unsigned              hold_left = 0;
   int unsigned              stall_left = 0;
   int unsigned              cycle_count = 0;

   mission_mode_sequencer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // cmd, rate x/y/z, base x/y/z, base_valid, comms, docked
      .req_tuser   (req_tuser),     // func
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // mode, attitude, prop, radio, role, dock, deploy
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic int unsigned gap_len(int unsigned pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 12;
         default: return 40;
      endcase
   endfunction

   function automatic int spread(int unsigned span);
      return int'($urandom_range(0, 2 * span)) - int'(span);
   endfunction

   function automatic logic [mms_pkg::ReqDataW-1:0] pack_request(sensor_item_type it);
      return {2'b00, it.is_docked, it.last_comms, it.base_valid, it.base_z, it.base_y,
              it.base_x, it.rate_z, it.rate_y, it.rate_x, it.cmd};
   endfunction

   // calm sensors, far baseline, fresh comms
   function automatic sensor_item_type quiet_item(mms_pkg::func_type f,
                                                  logic [mms_pkg::CmdW-1:0] c);
      sensor_item_type it;
      it.func = f;
      it.cmd = c;
      it.rate_x = '0;
      it.rate_y = '0;
      it.rate_z = '0;
      it.base_x = 24'sd1000000;
      it.base_y = 24'sd1000000;
      it.base_z = 24'sd1000000;
      it.base_valid = 1'b1;
      it.last_comms = board.tick_count;
      it.is_docked = 1'b0;
      return it;
   endfunction

   function automatic sensor_item_type random_item();
      sensor_item_type   it;
      int unsigned       pick;
      int unsigned       span;
      mms_pkg::mode_type favored[5] = '{mms_pkg::M_STANDBY, mms_pkg::M_FOLLOWER,
                                        mms_pkg::M_LEADER, mms_pkg::M_FCLOSE,
                                        mms_pkg::M_LCLOSE};
      it = quiet_item(mms_pkg::F_TICK, mms_pkg::CmdW'($urandom_range(0, 15)));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         it.func = mms_pkg::F_SET_MODE;
         if ($urandom_range(0, 1) == 0) it.cmd = favored[$urandom_range(0, 4)];
      end else if (pick < 17) begin
         it.func = mms_pkg::F_SET_ROLE;
         if ($urandom_range(0, 4) != 0) it.cmd = mms_pkg::CmdW'($urandom_range(0, 2));
      end else if (pick < 20) begin
         it.func = F_UNUSED;
      end
      pick = $urandom_range(0, 9);
      if (pick >= 7) begin
         it.rate_x = mms_pkg::RateW'($urandom());
         it.rate_y = mms_pkg::RateW'($urandom());
         it.rate_z = mms_pkg::RateW'($urandom());
      end else if (pick != 0) begin
         it.rate_x = mms_pkg::RateW'(spread(64));
         it.rate_y = mms_pkg::RateW'(spread(64));
         it.rate_z = mms_pkg::RateW'(spread(64));
      end
      pick = $urandom_range(0, 9);
      if (pick >= 7) begin
         it.base_x = mms_pkg::BaseW'($urandom());
         it.base_y = mms_pkg::BaseW'($urandom());
         it.base_z = mms_pkg::BaseW'($urandom());
      end else begin
         span = (pick < 4) ? 400 : 3000;
         it.base_x = mms_pkg::BaseW'(spread(span));
         it.base_y = mms_pkg::BaseW'(spread(span));
         it.base_z = mms_pkg::BaseW'(spread(span));
      end
      it.base_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 6) != 0) it.last_comms = board.tick_count - $urandom_range(0, 20);
      else it.last_comms = $urandom();
      it.is_docked = ($urandom_range(0, 2) == 0);
      return it;
   endfunction

   task automatic send_item(input sensor_item_type it);
      int unsigned idle;
      idle = gap_len(send_pct);
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_request(it);
      req_tuser <= it.func;
      do @(posedge clock); while (!req_tready);
      board.note_item(it);
   endtask

   task automatic run_random(int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 100 == 0) send_pct = pick_pct();
         send_item(random_item());
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input mms_pkg::reg_index_type idx,
                            input logic [mms_pkg::CsrDataW-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= mms_pkg::CsrAddrW'({idx, 3'b000});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.set_register(idx, value);
   endtask

   task automatic apply_config(input logic [mms_pkg::CsrDataW-1:0] deploy, rate, approach,
                               dock, silence);
      csr_write(mms_pkg::REG_DEPLOY_WAIT, deploy);
      csr_write(mms_pkg::REG_RATE_LIMIT, rate);
      csr_write(mms_pkg::REG_APPROACH, approach);
      csr_write(mms_pkg::REG_DOCK, dock);
      csr_write(mms_pkg::REG_MAX_SILENCE, silence);
   endtask

   // result side: random stalls, one long hold-off to back the pipe up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata);
            results_seen++;
            if (results_seen == PRESSURE_AT) hold_left = PRESSURE_CYCLES;
         end
         cycle_count++;
         if (cycle_count % 150 == 0) take_pct = pick_pct();
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = gap_len(take_pct);
            rsp_tready <= (stall_left == 0);
            if (stall_left != 0) stall_left--;
         end
      end
   end

   initial begin
      sensor_item_type it;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_pct = 20;
      apply_config(2, 32'h0004_0000, 4_000_000, 250_000, 10);

      // startup wait, then detumble with the largest rate, then settle
      repeat (3) send_item(quiet_item(mms_pkg::F_TICK, '0));
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.rate_x = 16'sh8000;
      it.rate_y = 16'sh8000;
      it.rate_z = 16'sh8000;
      send_item(it);
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      // designation above leader is dropped
      send_item(quiet_item(mms_pkg::F_SET_ROLE, CMD_BAD_ROLE));
      send_item(quiet_item(mms_pkg::F_SET_ROLE, mms_pkg::CmdW'(mms_pkg::R_FOLLOWER)));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      // close but baseline invalid
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.base_x = 24'sd5;
      it.base_y = 24'sd5;
      it.base_z = 24'sd5;
      it.base_valid = 1'b0;
      send_item(it);
      // comms loss back to standby
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.last_comms = board.tick_count - 100;
      send_item(it);
      send_item(quiet_item(mms_pkg::F_SET_ROLE, mms_pkg::CmdW'(mms_pkg::R_LEADER)));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      // comms loss and near together: close approach with role undecided
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.last_comms = board.tick_count - 100;
      it.base_x = 24'sd100;
      it.base_y = 24'sd100;
      it.base_z = 24'sd100;
      send_item(it);
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.base_x = 24'sd10;
      it.base_y = -24'sd10;
      it.base_z = 24'sd10;
      send_item(it);
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.is_docked = 1'b1;
      send_item(it);
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      send_item(quiet_item(mms_pkg::F_SET_MODE, mms_pkg::M_PAIRED));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      send_item(quiet_item(mms_pkg::F_SET_MODE, mms_pkg::M_JUNK));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      send_item(quiet_item(mms_pkg::F_SET_MODE, mms_pkg::M_MANUAL));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      send_item(quiet_item(mms_pkg::F_SET_MODE, M_INVALID));
      send_item(quiet_item(mms_pkg::F_TICK, '0));
      send_item(quiet_item(F_UNUSED, '1));
      it = quiet_item(mms_pkg::F_TICK, '0);
      it.base_x = 24'sh800000;
      it.base_y = 24'sh800000;
      it.base_z = 24'sh7FFFFF;
      send_item(it);

      run_random(500);
      drain();
      apply_config(15000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0);
      run_random(300);
      drain();
      apply_config(0, 0, 0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      run_random(300);
      drain();
      apply_config(5, 32'h0000_8000, 9_000_000, 1_000_000, 3);
      run_random(350);
      drain();

      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
